[hw/rtl/hccq_pkg.sv]
// ----------------------------------------------------------------------------
// hccq_pkg
// Shared codes and types of the HCI command credit queue: operation and
// status codes, packet constants and the event parser result.
// ----------------------------------------------------------------------------
package hccq_pkg;

  localparam logic [2:0] OP_CMD_BYTE  = 3'd0;
  localparam logic [2:0] OP_EVT_BYTE  = 3'd1;
  localparam logic [2:0] OP_PEEK      = 3'd2;
  localparam logic [2:0] OP_READ_BYTE = 3'd3;
  localparam logic [2:0] OP_MARK_SENT = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_BLOCKED  = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  localparam logic [7:0]  HCI_CMD_PKT      = 8'h01;
  localparam logic [7:0]  HCI_EVT_PKT      = 8'h04;
  localparam logic [7:0]  EVT_CMD_COMPLETE = 8'h0e;
  localparam logic [7:0]  EVT_CMD_STATUS   = 8'h0f;
  localparam logic [15:0] OPC_NO_ACK       = 16'h0c35;
  localparam logic [8:0]  CNT_MAX          = 9'd511;

  typedef enum logic [1:0] {
    EVT_INVALID,
    EVT_PASS,
    EVT_RELOAD
  } evt_kind_t;

  typedef struct packed {
    evt_kind_t   kind;
    logic [7:0]  credits;
    logic [15:0] opcode;
  } evt_res_t;

endpackage

[hw/rtl/hccq_ram.sv]
// ----------------------------------------------------------------------------
// hccq_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module hccq_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/hccq_evt_rx.sv]
// ----------------------------------------------------------------------------
// hccq_evt_rx
// Event packet receiver: collects the header bytes of an event and, on the
// last byte, classifies it and extracts credits and opcode.
// ----------------------------------------------------------------------------
module hccq_evt_rx
  import hccq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] byte_data,
  input  logic       byte_last,
  output evt_res_t   res
);

  localparam int HDR_N = 7;

  logic [7:0] hdr_r [HDR_N];
  logic [8:0] cnt_r;
  logic [8:0] cnt_nxt;
  logic [7:0] hdr_eff [HDR_N];
  logic       pos_in_hdr;
  logic [9:0] len;
  logic [9:0] plen_chk;

  assign pos_in_hdr = (cnt_r < 9'(HDR_N));
  assign len        = {1'b0, cnt_r} + 10'd1;

  always_comb begin
    for (int i = 0; i < HDR_N; i++) begin
      hdr_eff[i] = hdr_r[i];
    end
    if (pos_in_hdr) begin
      hdr_eff[cnt_r[2:0]] = byte_data;
    end
  end

  assign plen_chk = {2'b00, hdr_eff[2]} + 10'd3;

  always_comb begin
    res.kind    = EVT_INVALID;
    res.credits = hdr_eff[3];
    res.opcode  = {hdr_eff[5], hdr_eff[4]};
    if (len < 10'd3 || hdr_eff[0] != HCI_EVT_PKT || len != plen_chk) begin
      res.kind = EVT_INVALID;
    end else if (hdr_eff[1] == EVT_CMD_COMPLETE) begin
      res.kind = (len < 10'd6) ? EVT_INVALID : EVT_RELOAD;
    end else if (hdr_eff[1] == EVT_CMD_STATUS) begin
      res.kind    = (len < 10'd7) ? EVT_INVALID : EVT_RELOAD;
      res.credits = hdr_eff[4];
      res.opcode  = {hdr_eff[6], hdr_eff[5]};
    end else begin
      res.kind = EVT_PASS;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (byte_en) begin
      if (byte_last) begin
        cnt_nxt = '0;
      end else if (cnt_r < CNT_MAX) begin
        cnt_nxt = cnt_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && pos_in_hdr) begin
      hdr_r[cnt_r[2:0]] <= byte_data;
    end
  end

endmodule

[hw/rtl/hci_command_credit_queue_top.sv]
// ----------------------------------------------------------------------------
// hci_command_credit_queue_top
// Ring queue of HCI command packets with credit flow control. Packet bytes
// live in a packet memory, per-slot owner/length/opcode in a slot memory.
//
//   channel   ports                                   handshake
//   input     in_operation .. in_byte_index           start, busy
//   result    out_status .. out_read_data             out_valid strobe
//
// Each word has an accept and an execute cycle: the accept cycle issues the
// memory reads at the head slot, the execute cycle sees the read data, updates
// state and writes back. busy is high in the execute cycle, so no new word is
// accepted until the current one has executed. The result strobe is registered
// from the execute cycle and cannot be held off. Reset (rst_n low, synchronous)
// empties the queue and sets one credit; no memory clearing is needed.
// ----------------------------------------------------------------------------
module hci_command_credit_queue_top
  import hccq_pkg::*;
#(
  parameter int QUEUE_SLOTS      = 8,
  parameter int MAX_PACKET_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_owner_tag,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [8:0]  in_byte_index,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_head_owner,
  output logic [8:0]  out_head_length,
  output logic [15:0] out_head_opcode,
  output logic [7:0]  out_read_data
);

  localparam int SLOT_W    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CNT_W     = $clog2(QUEUE_SLOTS + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int PKT_DEPTH = QUEUE_SLOTS * MAX_PACKET_BYTES;
  localparam int PKT_AW    = (PKT_DEPTH > 1) ? $clog2(PKT_DEPTH) : 1;
  localparam int POS_W     = $clog2(MAX_PACKET_BYTES);
  localparam int DESC_W    = 8 + 9 + 16;

  localparam logic [9:0]        MAX_LEN  = 10'(MAX_PACKET_BYTES);
  localparam logic [PKT_AW-1:0] MAX_A    = PKT_AW'(MAX_PACKET_BYTES);
  localparam logic [SUM_W-1:0]  SLOTS_S  = SUM_W'(QUEUE_SLOTS);
  localparam logic [CNT_W-1:0]  SLOTS_C  = CNT_W'(QUEUE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  // queue and credit state
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        credits_r, credits_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic [15:0]       inflight_op_r, inflight_op_nxt;
  logic [8:0]        incoming_r, incoming_nxt;
  logic              dropped_r, dropped_nxt;
  logic [7:0]        cmd_type_r, cmd_type_nxt;
  logic [7:0]        cmd_plen_r, cmd_plen_nxt;
  logic [7:0]        cmd_op_lo_r, cmd_op_lo_nxt;
  logic [7:0]        cmd_op_hi_r, cmd_op_hi_nxt;

  // captured word
  logic [2:0] op_r;
  logic [7:0] owner_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [8:0] idx_r;

  // result registers
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  res_owner_r, res_owner_nxt;
  logic [8:0]  res_len_r, res_len_nxt;
  logic [15:0] res_op_r, res_op_nxt;
  logic [7:0]  res_data_r, res_data_nxt;

  logic              accept;
  logic              exec;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] tail;
  logic              full;

  logic              pkt_we;
  logic [PKT_AW-1:0] pkt_wr_addr;
  logic [PKT_AW-1:0] pkt_rd_addr;
  logic [7:0]        pkt_rd_data;

  logic              slot_we;
  logic [DESC_W-1:0] slot_wr_data;
  logic [DESC_W-1:0] slot_rd_data;
  logic [7:0]        head_owner;
  logic [8:0]        head_len;
  logic [15:0]       head_op;
  logic              head_blocked;

  logic [9:0]  cmd_len;
  logic [7:0]  cmd_type_cur;
  logic [7:0]  cmd_plen_cur;
  logic        cmd_ok;
  logic        evt_en;
  evt_res_t    evt_res;

  assign accept = start && (state_r == S_IDLE);
  assign exec   = (state_r == S_EXEC);
  assign busy   = exec;

  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SLOTS_S) ? SLOT_W'(tail_sum - SLOTS_S) : SLOT_W'(tail_sum);
  assign full     = (count_r == SLOTS_C);

  assign pkt_wr_addr = PKT_AW'(tail) * MAX_A + PKT_AW'(incoming_r[POS_W-1:0]);
  assign pkt_rd_addr = PKT_AW'(head_r) * MAX_A + PKT_AW'(in_byte_index[POS_W-1:0]);

  assign head_owner   = slot_rd_data[DESC_W-1 -: 8];
  assign head_len     = slot_rd_data[24:16];
  assign head_op      = slot_rd_data[15:0];
  assign head_blocked = (head_op != OPC_NO_ACK) && (awaiting_r || credits_r == 8'd0);

  // type and length bytes including the byte in execution
  assign cmd_type_cur = (incoming_r == 9'd0) ? byte_r : cmd_type_r;
  assign cmd_plen_cur = (incoming_r == 9'd3) ? byte_r : cmd_plen_r;

  assign cmd_len = {1'b0, incoming_r} + 10'd1;
  assign cmd_ok  = (cmd_len >= 10'd4) && (cmd_len == ({2'b00, cmd_plen_cur} + 10'd4)) &&
                   (cmd_type_cur == HCI_CMD_PKT) && (cmd_len <= MAX_LEN);

  assign slot_wr_data = {owner_r, cmd_len[8:0], cmd_op_hi_nxt, cmd_op_lo_nxt};

  assign evt_en = exec && (op_r == OP_EVT_BYTE);

  hccq_ram #(
    .DEPTH (PKT_DEPTH),
    .WIDTH (8),
    .AW    (PKT_AW)
  ) u_pkt_mem (
    .clk     (clk),
    .wr_en   (pkt_we),
    .wr_addr (pkt_wr_addr),
    .wr_data (byte_r),
    .rd_en   (accept),
    .rd_addr (pkt_rd_addr),
    .rd_data (pkt_rd_data)
  );

  hccq_ram #(
    .DEPTH (QUEUE_SLOTS),
    .WIDTH (DESC_W),
    .AW    (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (tail),
    .wr_data (slot_wr_data),
    .rd_en   (accept),
    .rd_addr (head_r),
    .rd_data (slot_rd_data)
  );

  hccq_evt_rx u_evt_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (evt_en),
    .byte_data (byte_r),
    .byte_last (last_r),
    .res       (evt_res)
  );

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    credits_nxt     = credits_r;
    awaiting_nxt    = awaiting_r;
    inflight_op_nxt = inflight_op_r;
    incoming_nxt    = incoming_r;
    dropped_nxt     = dropped_r;
    cmd_type_nxt    = cmd_type_r;
    cmd_plen_nxt    = cmd_plen_r;
    cmd_op_lo_nxt   = cmd_op_lo_r;
    cmd_op_hi_nxt   = cmd_op_hi_r;
    out_valid_nxt   = 1'b0;
    status_nxt      = ST_INVALID;
    res_owner_nxt   = '0;
    res_len_nxt     = '0;
    res_op_nxt      = '0;
    res_data_nxt    = '0;
    pkt_we          = 1'b0;
    slot_we         = 1'b0;

    // command byte capture, also feeds the last-byte check
    if (exec && op_r == OP_CMD_BYTE) begin
      if (incoming_r == 9'd0) cmd_type_nxt = byte_r;
      if (incoming_r == 9'd1) cmd_op_lo_nxt = byte_r;
      if (incoming_r == 9'd2) cmd_op_hi_nxt = byte_r;
      if (incoming_r == 9'd3) cmd_plen_nxt = byte_r;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (op_r)
          OP_CMD_BYTE: begin
            if (full) begin
              dropped_nxt = 1'b1;
            end else if ({1'b0, incoming_r} < MAX_LEN) begin
              pkt_we = 1'b1;
            end
            if (incoming_r < CNT_MAX) begin
              incoming_nxt = incoming_r + 9'd1;
            end
            if (!last_r) begin
              out_valid_nxt = 1'b0;
            end else begin
              incoming_nxt = '0;
              dropped_nxt  = 1'b0;
              cmd_type_nxt = '0;
              cmd_plen_nxt = '0;
              if (!cmd_ok) begin
                status_nxt = ST_INVALID;
              end else if (dropped_r || full) begin
                status_nxt = ST_FULL;
              end else begin
                slot_we    = 1'b1;
                count_nxt  = count_r + 1'b1;
                status_nxt = ST_OK;
              end
            end
          end
          OP_EVT_BYTE: begin
            if (!last_r) begin
              out_valid_nxt = 1'b0;
            end else begin
              case (evt_res.kind)
                EVT_INVALID: status_nxt = ST_INVALID;
                EVT_PASS:    status_nxt = ST_OK;
                EVT_RELOAD: begin
                  credits_nxt = evt_res.credits;
                  status_nxt  = ST_OK;
                  if (awaiting_r) begin
                    if (evt_res.opcode != inflight_op_r) begin
                      status_nxt = ST_MISMATCH;
                    end else begin
                      awaiting_nxt    = 1'b0;
                      inflight_op_nxt = '0;
                    end
                  end
                end
                default: status_nxt = ST_INVALID;
              endcase
            end
          end
          OP_PEEK: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (head_blocked) begin
              status_nxt = ST_BLOCKED;
            end else begin
              status_nxt    = ST_OK;
              res_owner_nxt = head_owner;
              res_len_nxt   = head_len;
              res_op_nxt    = head_op;
            end
          end
          OP_READ_BYTE: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (idx_r >= head_len || {1'b0, idx_r} >= MAX_LEN) begin
              status_nxt = ST_INVALID;
            end else begin
              status_nxt   = ST_OK;
              res_data_nxt = pkt_rd_data;
            end
          end
          OP_MARK_SENT: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (head_blocked) begin
              status_nxt = ST_BLOCKED;
            end else begin
              if (head_op != OPC_NO_ACK) begin
                awaiting_nxt    = 1'b1;
                inflight_op_nxt = head_op;
                credits_nxt     = credits_r - 8'd1;
              end
              head_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
              count_nxt  = count_r - 1'b1;
              status_nxt = ST_OK;
            end
          end
          default: status_nxt = ST_INVALID;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      head_r        <= '0;
      count_r       <= '0;
      credits_r     <= 8'd1;
      awaiting_r    <= 1'b0;
      inflight_op_r <= '0;
      incoming_r    <= '0;
      dropped_r     <= 1'b0;
      cmd_type_r    <= '0;
      cmd_plen_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      credits_r     <= credits_nxt;
      awaiting_r    <= awaiting_nxt;
      inflight_op_r <= inflight_op_nxt;
      incoming_r    <= incoming_nxt;
      dropped_r     <= dropped_nxt;
      cmd_type_r    <= cmd_type_nxt;
      cmd_plen_r    <= cmd_plen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_op_lo_r <= cmd_op_lo_nxt;
    cmd_op_hi_r <= cmd_op_hi_nxt;
    status_r    <= status_nxt;
    res_owner_r <= res_owner_nxt;
    res_len_r   <= res_len_nxt;
    res_op_r    <= res_op_nxt;
    res_data_r  <= res_data_nxt;
    if (accept) begin
      op_r    <= in_operation;
      owner_r <= in_owner_tag;
      byte_r  <= in_data_byte;
      last_r  <= in_last_byte;
      idx_r   <= in_byte_index;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_head_owner  = res_owner_r;
  assign out_head_length = res_len_r;
  assign out_head_opcode = res_op_r;
  assign out_read_data   = res_data_r;

endmodule
